/* hw/rtl/nrfp_pkg.sv */
// Types and constants shared by the NFC response frame parser modules.
`default_nettype none

package nrfp_pkg;

  localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
  localparam logic [7:0] START1_BYTE   = 8'h00;
  localparam logic [7:0] START2_BYTE   = 8'hFF;
  localparam logic [7:0] TFI_BYTE      = 8'hD5;
  localparam logic [7:0] MIN_LEN       = 8'd2;
  localparam logic [7:0] CAP_RESET     = 8'd255;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START1  = 4'd1,
    PH_START2  = 4'd2,
    PH_LEN     = 4'd3,
    PH_LCS     = 4'd4,
    PH_TFI     = 4'd5,
    PH_ECHO    = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_DCS     = 4'd8,
    PH_POST    = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic [7:0] expected_command;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    status_e    frame_status;
    logic [7:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/nfc_response_frame_parser.sv */
// Top level of the NFC response frame parser with stream ports and a capacity register.
// Latency: an accepted word is held in the input register, and its result word is registered in the result register.
// Throughput: one received byte per cycle while the result register can take a result.
// A result word that the sink does not take stalls the parser, and the input register then holds at most one more byte.
// Reset puts the parser in the idle phase, empties both register stages and sets
// the buffer capacity to 255.
`default_nettype none

module nfc_response_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // rx_byte, expected_command
  input  wire logic        s_axis_tuser,  // frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // payload_byte, payload_index, frame_status,
                                          // payload_length, zero fill
  output logic [1:0]       m_axis_tuser,  // payload_valid, frame_done
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);

  nrfp_pkg::item_t   in_item, held_item;
  nrfp_pkg::result_t step_res, out_res;
  logic              held_valid, advance, out_ready, step_valid;
  logic [7:0]        cap_q;

  assign in_item.rx_byte          = s_axis_tdata[7:0];
  assign in_item.expected_command = s_axis_tdata[15:8];
  assign in_item.frame_start      = s_axis_tuser;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= nrfp_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign advance = held_valid && out_ready;

  nrfp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  nrfp_step u_step (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (advance),
    .item_i            (held_item),
    .buffer_capacity_i (cap_q),
    .res_valid_o       (step_valid),
    .res_o             (step_res)
  );

  nrfp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && step_valid),
    .res_i   (step_res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.payload_length, out_res.frame_status,
                         out_res.payload_index, out_res.payload_byte};
  assign m_axis_tuser = {out_res.frame_done, out_res.payload_valid};

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tuser))
    else $error("Result word must carry either a payload byte or a frame end.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_res.frame_status == nrfp_pkg::ST_OK ||
                       out_res.frame_status == nrfp_pkg::ST_INVALID ||
                       out_res.frame_status == nrfp_pkg::ST_NOSPACE))
    else $error("Unused frame status code on the output.");

  a_bad_preamble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && held_item.frame_start && held_item.rx_byte != nrfp_pkg::PREAMBLE_BYTE)
    |=> (m_axis_tvalid && out_res.frame_done &&
         out_res.frame_status == nrfp_pkg::ST_INVALID))
    else $error("Bad preamble did not report an invalid frame.");

  a_length_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.payload_length != 8'd0) |->
    (out_res.frame_done && out_res.frame_status == nrfp_pkg::ST_OK))
    else $error("Payload length reported on a frame that did not end ok.");

endmodule

`default_nettype wire

/* hw/rtl/nrfp_in_reg.sv */
// Input register stage that holds one received word until the parser takes it.
`default_nettype none

module nrfp_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire nrfp_pkg::item_t item_i,
  input  wire logic          advance_i,
  output logic               valid_o,
  output nrfp_pkg::item_t    item_o
);

  logic            valid_q, valid_d;
  nrfp_pkg::item_t item_q;
  logic            accept;

  assign ready_o = !valid_q || advance_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* hw/rtl/nrfp_step.sv */
// Frame parser state machine: checks one byte per cycle while enabled and forms its result.
`default_nettype none

module nrfp_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire nrfp_pkg::item_t item_i,
  input  wire logic [7:0]      buffer_capacity_i,
  output logic                 res_valid_o,
  output nrfp_pkg::result_t    res_o
);

  nrfp_pkg::phase_e phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] length_q, length_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] echo_q, echo_d;
  logic [7:0] count_q, count_d;
  logic       ovf_q, ovf_d;

  logic [7:0] b;
  logic [7:0] left_dec;
  logic [7:0] left_init;

  assign b         = item_i.rx_byte;
  assign left_dec  = bytes_left_q - 8'd1;
  assign left_init = length_q - nrfp_pkg::MIN_LEN;

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    length_d     = length_q;
    sum_d        = sum_q;
    echo_d       = echo_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    if (item_i.frame_start) begin
      echo_d       = item_i.expected_command + 8'd1;
      bytes_left_d = 8'd0;
      length_d     = 8'd0;
      sum_d        = 8'd0;
      count_d      = 8'd0;
      ovf_d        = 1'b0;
      phase_d      = (b == nrfp_pkg::PREAMBLE_BYTE) ? nrfp_pkg::PH_START1 : nrfp_pkg::PH_IDLE;
    end else begin
      case (phase_q)
        nrfp_pkg::PH_IDLE: begin
          phase_d = nrfp_pkg::PH_IDLE;
        end
        nrfp_pkg::PH_START1: begin
          phase_d = (b == nrfp_pkg::START1_BYTE) ? nrfp_pkg::PH_START2 : nrfp_pkg::PH_IDLE;
        end
        nrfp_pkg::PH_START2: begin
          phase_d = (b == nrfp_pkg::START2_BYTE) ? nrfp_pkg::PH_LEN : nrfp_pkg::PH_IDLE;
        end
        nrfp_pkg::PH_LEN: begin
          length_d = b;
          phase_d  = nrfp_pkg::PH_LCS;
        end
        nrfp_pkg::PH_LCS: begin
          if ((length_q + b) != 8'd0 || length_q < nrfp_pkg::MIN_LEN) begin
            phase_d = nrfp_pkg::PH_IDLE;
          end else begin
            phase_d = nrfp_pkg::PH_TFI;
          end
        end
        nrfp_pkg::PH_TFI: begin
          phase_d = (b == nrfp_pkg::TFI_BYTE) ? nrfp_pkg::PH_ECHO : nrfp_pkg::PH_IDLE;
        end
        nrfp_pkg::PH_ECHO: begin
          if (b != echo_q) begin
            phase_d = nrfp_pkg::PH_IDLE;
          end else begin
            bytes_left_d = left_init;
            sum_d        = nrfp_pkg::TFI_BYTE + b;
            count_d      = 8'd0;
            ovf_d        = left_init > buffer_capacity_i;
            phase_d      = (left_init != 8'd0) ? nrfp_pkg::PH_PAYLOAD : nrfp_pkg::PH_DCS;
          end
        end
        nrfp_pkg::PH_PAYLOAD: begin
          bytes_left_d = left_dec;
          count_d      = count_q + 8'd1;
          if (left_dec == 8'd0) begin
            phase_d = nrfp_pkg::PH_DCS;
          end
          if (!ovf_q) begin
            sum_d = sum_q + b;
          end
        end
        nrfp_pkg::PH_DCS: begin
          if (!ovf_q && (sum_q + b) != 8'd0) begin
            phase_d = nrfp_pkg::PH_IDLE;
          end else begin
            phase_d = nrfp_pkg::PH_POST;
          end
        end
        nrfp_pkg::PH_POST: begin
          phase_d = nrfp_pkg::PH_IDLE;
        end
        default: begin
          phase_d = nrfp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result.
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.payload_valid  = 1'b0;
    res_o.payload_byte   = 8'd0;
    res_o.payload_index  = 8'd0;
    res_o.frame_done     = 1'b0;
    res_o.frame_status   = nrfp_pkg::ST_OK;
    res_o.payload_length = 8'd0;
    if (item_i.frame_start) begin
      if (b != nrfp_pkg::PREAMBLE_BYTE) begin
        res_valid_o        = 1'b1;
        res_o.frame_done   = 1'b1;
        res_o.frame_status = nrfp_pkg::ST_INVALID;
      end
    end else begin
      case (phase_q)
        nrfp_pkg::PH_START1: begin
          if (b != nrfp_pkg::START1_BYTE) begin
            res_valid_o        = 1'b1;
            res_o.frame_done   = 1'b1;
            res_o.frame_status = nrfp_pkg::ST_INVALID;
          end
        end
        nrfp_pkg::PH_START2: begin
          if (b != nrfp_pkg::START2_BYTE) begin
            res_valid_o        = 1'b1;
            res_o.frame_done   = 1'b1;
            res_o.frame_status = nrfp_pkg::ST_INVALID;
          end
        end
        nrfp_pkg::PH_LCS: begin
          if ((length_q + b) != 8'd0 || length_q < nrfp_pkg::MIN_LEN) begin
            res_valid_o        = 1'b1;
            res_o.frame_done   = 1'b1;
            res_o.frame_status = nrfp_pkg::ST_INVALID;
          end
        end
        nrfp_pkg::PH_TFI: begin
          if (b != nrfp_pkg::TFI_BYTE) begin
            res_valid_o        = 1'b1;
            res_o.frame_done   = 1'b1;
            res_o.frame_status = nrfp_pkg::ST_INVALID;
          end
        end
        nrfp_pkg::PH_ECHO: begin
          if (b != echo_q) begin
            res_valid_o        = 1'b1;
            res_o.frame_done   = 1'b1;
            res_o.frame_status = nrfp_pkg::ST_INVALID;
          end
        end
        nrfp_pkg::PH_PAYLOAD: begin
          if (!ovf_q) begin
            res_valid_o         = 1'b1;
            res_o.payload_valid = 1'b1;
            res_o.payload_byte  = b;
            res_o.payload_index = count_q;
          end
        end
        nrfp_pkg::PH_DCS: begin
          if (!ovf_q && (sum_q + b) != 8'd0) begin
            res_valid_o        = 1'b1;
            res_o.frame_done   = 1'b1;
            res_o.frame_status = nrfp_pkg::ST_INVALID;
          end
        end
        nrfp_pkg::PH_POST: begin
          res_valid_o      = 1'b1;
          res_o.frame_done = 1'b1;
          if (ovf_q) begin
            res_o.frame_status = nrfp_pkg::ST_NOSPACE;
          end else begin
            res_o.payload_length = count_q;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= nrfp_pkg::PH_IDLE;
      bytes_left_q <= 8'd0;
      length_q     <= 8'd0;
      sum_q        <= 8'd0;
      echo_q       <= 8'd0;
      count_q      <= 8'd0;
      ovf_q        <= 1'b0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      length_q     <= length_d;
      sum_q        <= sum_d;
      echo_q       <= echo_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nrfp_out_reg.sv */
// Result register that holds one result word until the sink takes it.
`default_nettype none

module nrfp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire nrfp_pkg::result_t res_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output nrfp_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  nrfp_pkg::result_t res_q;

  assign ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire
